// ===== rtl/core/nat_pkg.sv =====
// Package for the nearest-angle table lookup block.
// Holds field widths, request kind codes, register indexes and reset values.
// No dependencies; every other file of the block uses it.
package nat_pkg;

   localparam int KIND_W     = 2;
   localparam int INDEX_W    = 12;
   localparam int ANGLE_W    = 17;
   localparam int FOUND_W    = 10;
   localparam int DIFF_W     = ANGLE_W + 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ROW_COUNT_W = 7;
   localparam int COL_COUNT_W = 11;

   typedef logic [KIND_W-1:0]         kind_type;
   typedef logic signed [INDEX_W-1:0] index_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [FOUND_W-1:0]        found_type;
   typedef logic [DIFF_W-1:0]         diff_type;
   typedef logic [0:0]                reg_index_type;

   localparam kind_type KIND_WRITE  = 2'd0;
   localparam kind_type KIND_LOOKUP = 2'd1;
   localparam kind_type KIND_READ   = 2'd2;

   localparam reg_index_type REG_ROW_COUNT = 1'b0;
   localparam reg_index_type REG_COL_COUNT = 1'b1;

   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 7'd16;
   localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = 11'd1024;

endpackage

// ===== rtl/core/nat_req_if.sv =====
// Request channel of the nearest-angle table lookup block.
// Carries valid, ready and one request; depends on nat_pkg.
interface nat_req_if;
   logic                valid;
   logic                ready;
   nat_pkg::kind_type   kind;
   logic                table_select;
   nat_pkg::index_type  entry_index;
   nat_pkg::angle_type  angle_value;

   modport source (output valid, kind, table_select, entry_index, angle_value, input ready);
   modport sink   (input valid, kind, table_select, entry_index, angle_value, output ready);
endinterface

// ===== rtl/core/nat_rsp_if.sv =====
// Result channel of the nearest-angle table lookup block.
// Carries valid, ready and one result; depends on nat_pkg.
interface nat_rsp_if;
   logic                valid;
   logic                ready;
   nat_pkg::found_type  found_index;
   nat_pkg::angle_type  angle_out;
   logic                out_of_range;

   modport source (output valid, found_index, angle_out, out_of_range, input ready);
   modport sink   (input valid, found_index, angle_out, out_of_range, output ready);
endinterface

// ===== rtl/core/nearest_angle_table_lookup.sv =====
// Top level of the nearest-angle table lookup block.
// Two angle tables in synchronous memories, a search sequencer and an APB register port.
// Depends on nat_pkg, nat_req_if and nat_rsp_if.
//
// Requests arrive on req_bus; lookups and reads give one result on rsp_bus, writes none.
// A write stores an entry at the edge that accepts it, and the next request can follow
// in the next cycle. A read passes through an address, a data and an output state; an
// invalid index goes straight to the output state. A lookup reads the first and last
// entries in use to find the table direction, runs an upper-bound halving search with
// one memory probe per cycle, then reads the two neighbors of the crossing and compares
// distances; when the key clamps to an end entry, the neighbor reads are skipped. The
// next request can be accepted in the same cycle that a result is shown. Each table
// memory has a single registered read port. One request is worked on at a time. The
// result sits in an output register, so a new request is accepted while an earlier
// result still waits for rsp_bus.ready; a stalled receiver only holds back the next
// result. Reset clears the control state and loads the counts (16 rows, 1024 columns);
// table contents are undefined until software writes them.
// Counts are to be written through the APB port only while the block is idle; the
// user must keep to this, as the block itself does not enforce it.
module nearest_angle_table_lookup #(
   parameter int ROW_DEPTH = 64,
   parameter int COL_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   nat_req_if.sink                          req_bus,
   nat_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [nat_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nat_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nat_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import nat_pkg::*;

   localparam int RAW  = $clog2(ROW_DEPTH);
   localparam int CAW  = $clog2(COL_DEPTH);
   localparam int MAXD = (ROW_DEPTH > COL_DEPTH) ? ROW_DEPTH : COL_DEPTH;
   localparam int NW   = $clog2(MAXD + 1);
   localparam int XW   = ((NW > INDEX_W) ? NW : INDEX_W) + 2;

   typedef logic [NW-1:0]        cnt_type;
   typedef logic signed [XW-1:0] wide_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LK_FIRST, ST_LK_LAST, ST_LK_DIR, ST_LK_SRCH, ST_LK_FIX,
      ST_LK_NB1, ST_LK_NB2, ST_LK_CMP, ST_RD_ADDR, ST_RD_DATA, ST_OUT
   } state_type;

   function automatic diff_type abs_diff(angle_type a, angle_type b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      abs_diff = d[DIFF_W-1] ? diff_type'(-d) : diff_type'(d);
   endfunction

   logic [ROW_COUNT_W-1:0] row_count_ff;
   logic [COL_COUNT_W-1:0] col_count_ff;

   angle_type row_mem [ROW_DEPTH];
   angle_type col_mem [COL_DEPTH];
   angle_type row_rd_ff, col_rd_ff, rd_data;
   cnt_type   rd_addr;
   logic      row_we, col_we, req_acc;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in, rev_ff, rev_in;
   index_type idx_ff, idx_in;
   angle_type key_ff, key_in, t0_ff, t0_in;
   cnt_type   n_ff, n_in, first_ff, first_in, count_ff, count_in, f_ff, f_in;
   diff_type  dn_ff, dn_in, dp_ff, dp_in;
   found_type res_found_ff, res_found_in, rsp_found_ff, rsp_found_in;
   angle_type res_angle_ff, res_angle_in, rsp_angle_ff, rsp_angle_in;
   logic      res_oor_ff, res_oor_in, rsp_oor_ff, rsp_oor_in;
   logic      rsp_valid_ff, rsp_valid_in;

   cnt_type   row_n, col_n, nm1, half_n, step, it, f_r, c_r, it_r, it_l;
   cnt_type   addr_r, addr_l, count_next, f_calc, f_m1;
   logic      go_right;
   wide_type  idx_x, n_x, rd_a;
   logic      rd_bad;

   // Configuration registers.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RST;
         col_count_ff <= COL_COUNT_RST;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_ROW_COUNT: row_count_ff <= pwdata[ROW_COUNT_W-1:0];
            REG_COL_COUNT: col_count_ff <= pwdata[COL_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ROW_COUNT: prdata = CSR_DATA_W'(row_count_ff);
         REG_COL_COUNT: prdata = CSR_DATA_W'(col_count_ff);
         default:       prdata = '0;
      endcase
   end

   assign row_n = NW'((row_count_ff == '0) ? 1 :
                      (int'(row_count_ff) > ROW_DEPTH) ? ROW_DEPTH : int'(row_count_ff));
   assign col_n = NW'((col_count_ff == '0) ? 1 :
                      (int'(col_count_ff) > COL_DEPTH) ? COL_DEPTH : int'(col_count_ff));

   // Table memories: one write and one registered read per cycle each.
   assign req_acc = req_bus.valid && req_bus.ready;
   assign row_we  = req_acc && (req_bus.kind == KIND_WRITE) && !req_bus.table_select &&
                    !req_bus.entry_index[INDEX_W-1] && (int'(req_bus.entry_index) < ROW_DEPTH);
   assign col_we  = req_acc && (req_bus.kind == KIND_WRITE) && req_bus.table_select &&
                    !req_bus.entry_index[INDEX_W-1] && (int'(req_bus.entry_index) < COL_DEPTH);

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[req_bus.entry_index[RAW-1:0]] <= req_bus.angle_value;
      end
      row_rd_ff <= row_mem[rd_addr[RAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[req_bus.entry_index[CAW-1:0]] <= req_bus.angle_value;
      end
      col_rd_ff <= col_mem[rd_addr[CAW-1:0]];
   end

   assign rd_data = sel_ff ? col_rd_ff : row_rd_ff;

   // Search arithmetic: both outcomes of a probe are prepared from registers.
   assign nm1    = n_ff - NW'(1);
   assign half_n = n_ff >> 1;
   assign step   = count_ff >> 1;
   assign it     = first_ff + step;
   assign f_r    = it + NW'(1);
   assign c_r    = count_ff - step - NW'(1);
   assign it_r   = f_r + (c_r >> 1);
   assign it_l   = first_ff + (step >> 1);
   assign addr_r = rev_ff ? nm1 - it_r : it_r;
   assign addr_l = rev_ff ? nm1 - it_l : it_l;
   assign go_right   = !(key_ff < rd_data);
   assign count_next = go_right ? c_r : step;
   assign f_calc = rev_ff ? n_ff - first_ff : first_ff;
   assign f_m1   = f_ff - NW'(1);

   // Read index check with a single column wrap.
   assign idx_x = XW'(idx_ff);
   assign n_x   = $signed({{(XW-NW){1'b0}}, n_ff});

   always_comb begin
      rd_a = idx_x;
      if (sel_ff) begin
         if (idx_x < 0) begin
            rd_a = idx_x + n_x;
         end else if (idx_x >= n_x) begin
            rd_a = idx_x - n_x;
         end
      end
      rd_bad = (rd_a < 0) || (rd_a >= n_x);
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found_index = rsp_found_ff;
   assign rsp_bus.angle_out   = rsp_angle_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      rev_in       = rev_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      t0_in        = t0_ff;
      n_in         = n_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      f_in         = f_ff;
      dn_in        = dn_ff;
      dp_in        = dp_ff;
      res_found_in = res_found_ff;
      res_angle_in = res_angle_ff;
      res_oor_in   = res_oor_ff;
      rsp_found_in = rsp_found_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rd_addr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sel_in       = req_bus.table_select;
               idx_in       = req_bus.entry_index;
               key_in       = req_bus.angle_value;
               n_in         = req_bus.table_select ? col_n : row_n;
               res_found_in = '0;
               res_angle_in = '0;
               res_oor_in   = 1'b0;
               case (req_bus.kind)
                  KIND_LOOKUP: state_in = ST_LK_FIRST;
                  KIND_READ:   state_in = ST_RD_ADDR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_LK_FIRST: begin
            rd_addr  = '0;
            state_in = ST_LK_LAST;
         end
         ST_LK_LAST: begin
            rd_addr  = nm1;
            t0_in    = rd_data;
            state_in = ST_LK_DIR;
         end
         ST_LK_DIR: begin
            rev_in   = !(t0_ff < rd_data);
            first_in = '0;
            count_in = n_ff;
            rd_addr  = (t0_ff < rd_data) ? half_n : nm1 - half_n;
            state_in = ST_LK_SRCH;
         end
         ST_LK_SRCH: begin
            first_in = go_right ? f_r : first_ff;
            count_in = count_next;
            rd_addr  = go_right ? addr_r : addr_l;
            if (count_next == '0) begin
               state_in = ST_LK_FIX;
            end
         end
         ST_LK_FIX: begin
            f_in = f_calc;
            if (f_calc == '0) begin
               res_found_in = '0;
               state_in     = ST_OUT;
            end else if (f_calc == n_ff) begin
               res_found_in = FOUND_W'(nm1);
               state_in     = ST_OUT;
            end else begin
               rd_addr  = f_calc;
               state_in = ST_LK_NB1;
            end
         end
         ST_LK_NB1: begin
            dn_in    = abs_diff(rd_data, key_ff);
            rd_addr  = f_m1;
            state_in = ST_LK_NB2;
         end
         ST_LK_NB2: begin
            dp_in    = abs_diff(key_ff, rd_data);
            state_in = ST_LK_CMP;
         end
         ST_LK_CMP: begin
            res_found_in = FOUND_W'((dn_ff < dp_ff) ? f_ff : f_m1);
            state_in     = ST_OUT;
         end
         ST_RD_ADDR: begin
            if (rd_bad) begin
               res_oor_in = 1'b1;
               state_in   = ST_OUT;
            end else begin
               rd_addr  = rd_a[NW-1:0];
               state_in = ST_RD_DATA;
            end
         end
         ST_RD_DATA: begin
            res_angle_in = rd_data;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_angle_in = res_angle_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sel_ff       <= sel_in;
      rev_ff       <= rev_in;
      idx_ff       <= idx_in;
      key_ff       <= key_in;
      t0_ff        <= t0_in;
      n_ff         <= n_in;
      first_ff     <= first_in;
      count_ff     <= count_in;
      f_ff         <= f_in;
      dn_ff        <= dn_in;
      dp_ff        <= dp_in;
      res_found_ff <= res_found_in;
      res_angle_ff <= res_angle_in;
      res_oor_ff   <= res_oor_in;
      rsp_found_ff <= rsp_found_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_oor_ff   <= rsp_oor_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/nat_checker.sv =====
// Port-level checks for the nearest-angle table lookup block.
// Depends on nat_pkg; bound to nearest_angle_table_lookup at the end of this file.
module nat_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input nat_pkg::kind_type  req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input nat_pkg::found_type rsp_found_index,
   input nat_pkg::angle_type rsp_angle_out,
   input logic               rsp_out_of_range
);
   import nat_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_bad_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_angle_out == '0 && rsp_found_index == '0)
      else $error("invalid read carries data");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("write request produced a result");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_LOOKUP |=> !req_ready)
      else $error("lookup did not hold off the next request");

endmodule

bind nearest_angle_table_lookup nat_checker u_nat_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_kind         (req_bus.kind),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_found_index  (rsp_bus.found_index),
   .rsp_angle_out    (rsp_bus.angle_out),
   .rsp_out_of_range (rsp_bus.out_of_range)
);
